/* hw/rtl/letter_keyframe_waveform_defines.svh */
// assertion macros for the rtl of the keyframe waveform block
`ifndef LETTER_KEYFRAME_WAVEFORM_DEFINES_SVH
`define LETTER_KEYFRAME_WAVEFORM_DEFINES_SVH

// property that must hold in the same cycle
`define LKW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define LKW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lkw_pkg.sv */
// ----------------------------------------------------------------------------
// lkw_pkg
// types, constants and key lookup for the letter keyframe waveform block
// ----------------------------------------------------------------------------
`default_nettype none

package lkw_pkg;

	localparam int DATA_W        = 32;
	localparam int CFG_W         = 40;
	localparam int CFG_IDX_W     = 3;
	localparam int KEY_W         = 5;
	localparam int KEY_IDX_W     = 4;
	localparam int KEYS_W        = 80;
	localparam int KEY_MAX_CODE  = 25;
	localparam int LEVEL_STEPS   = 25;
	localparam int DEF_MAX_KEYS  = 16;
	localparam int DEF_FRAC_BITS = 16;
	// quotient width of the level division and its biased numerator width
	localparam int LVL_QW        = 39;
	localparam int LVL_UW        = LVL_QW + 4;

	localparam logic signed [31:0] RST_VALUE_A = 32'sd0;
	localparam logic signed [31:0] RST_VALUE_Z = 32'sd65536;
	localparam logic [31:0]        RST_PERIOD  = 32'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VALUE_A,
		CFG_VALUE_Z,
		CFG_PERIOD,
		CFG_KEY_COUNT,
		CFG_KEYS_LOW,
		CFG_KEYS_HIGH,
		CFG_SMOOTH,
		CFG_MULTIPLY
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] value_a;
		logic [31:0]        period;
		logic [KEYS_W-1:0]  keys;
		logic               smooth;
		logic               multiply;
		logic               active;
		logic [KEY_IDX_W-1:0] nm1;
		logic signed [32:0] delta;
	} cfg_t;

	function automatic logic [KEY_W-1:0] key_at(logic [KEYS_W-1:0] keys,
			logic [KEY_IDX_W-1:0] idx);
		logic [KEY_W-1:0] code;
		code = keys[KEY_W*idx +: KEY_W];
		if (code > KEY_W'(KEY_MAX_CODE))
			code = KEY_W'(KEY_MAX_CODE);
		return code;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/letter_keyframe_waveform.sv */
// ----------------------------------------------------------------------------
// letter_keyframe_waveform
// keyframe animation channel: time wrap, key scaling, interpolation, scaling
// ----------------------------------------------------------------------------
// channel  | handshake               | payload
// in       | in_valid / in_stall     | time_now, base_value
// out      | out_valid / out_stall   | level_out, animated
// config   | cfg_we                  | cfg_index, cfg_wdata
//
// one transaction per cycle while the output is not stalled; the path runs through
// two bit-serial divider pipelines, interpolation, a divide-by-25 and output stages
// reset clears all valid bits and loads the register defaults, no clearing pass
// a stalled output freezes the whole pipeline; in_stall follows it
// ----------------------------------------------------------------------------
`default_nettype none

`include "letter_keyframe_waveform_defines.svh"

module letter_keyframe_waveform
	import lkw_pkg::*;
#(
	parameter int MAX_KEYS  = DEF_MAX_KEYS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [DATA_W-1:0]    time_now,
	input  wire logic signed [DATA_W-1:0] base_value,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [DATA_W-1:0]  level_out,
	output logic                      animated,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	localparam int F  = FRAC_BITS;
	localparam int KB = $clog2(MAX_KEYS);
	localparam int SQ = KB + F;
	localparam int NW = DATA_W + KB;
	localparam int SW = DATA_W + 1;
	localparam logic [LVL_QW-1:0] QOFS = {1'b1, {(LVL_QW-1){1'b0}}};
	localparam logic signed [63:0] HALF_C = 64'sd1 <<< (F - 1);
	// division by 25: one byte of the dividend per stage
	localparam int D25_CW   = 8;
	localparam int D25_NS   = (LVL_UW + D25_CW - 1) / D25_CW;
	localparam int D25_UW   = D25_NS * D25_CW;
	localparam int D25_VW   = KEY_W + D25_CW;
	localparam int PRD_W    = 2 * D25_VW;
	localparam int RECIP_SH = 17;
	// ceil(2^17 / 25), exact for partial dividends below 25 * 256
	localparam logic [D25_VW-1:0] RECIP25 = 13'd5243;

	cfg_t cfg;
	logic adv;

	logic              mod_v;
	logic [DATA_W-1:0] mod_quo, mod_rem;
	logic [SW-1:0]     mod_side;

	logic              nm_v_s;
	logic [NW-1:0]     nm_s;
	logic [SW-1:0]     nm_side_s;

	logic              sc_v;
	logic [SQ-1:0]     sc_quo;
	logic [DATA_W-1:0] sc_rem;
	logic [SW-1:0]     sc_side;

	logic              ip_v;
	logic [LVL_UW-1:0] ip_u;
	logic [DATA_W-1:0] ip_base;
	logic              ip_act;

	logic              d25_v_s    [D25_NS];
	logic [D25_UW-1:0] d25_num_s  [D25_NS];
	logic [D25_UW-1:0] d25_quo_s  [D25_NS];
	logic [KEY_W-1:0]  d25_rem_s  [D25_NS];
	logic [SW-1:0]     d25_side_s [D25_NS];

	logic              d25_v;
	logic [LVL_QW-1:0] d25_quo;
	logic [SW-1:0]     d25_side;

	logic              lvl_v_s;
	logic signed [DATA_W-1:0] lvl_s, lvl_base_s;
	logic              lvl_act_s;

	logic              mp_v_s;
	logic signed [63:0] mprod_s;
	logic signed [DATA_W-1:0] mp_lvl_s, mp_base_s;
	logic              mp_act_s;

	logic signed [63:0] mr, msh;
	logic signed [DATA_W-1:0] msat;
	logic              out_valid_q, animated_q;
	logic signed [DATA_W-1:0] level_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	lkw_cfg #(.MAX_KEYS(MAX_KEYS)) u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .cfg(cfg)
	);

	// time modulo period
	lkw_divpipe #(.QB(DATA_W), .DW(DATA_W), .SW(SW)) u_mod (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_v(in_valid),
		.rem_init('0), .qn_init(time_now), .den(cfg.period),
		.side_in({base_value, cfg.active}),
		.out_v(mod_v), .quo(mod_quo), .rem(mod_rem), .side_out(mod_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			nm_v_s <= 1'b0;
		else if (adv)
			nm_v_s <= mod_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_s      <= NW'(mod_rem) * NW'(cfg.nm1[KB-1:0]);
			nm_side_s <= mod_side;
		end
	end

	// position on the key sequence, KB integer and F fraction bits
	lkw_divpipe #(.QB(SQ), .DW(DATA_W), .SW(SW)) u_scale (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_v(nm_v_s),
		.rem_init(nm_s[NW-1:KB]), .qn_init({nm_s[KB-1:0], {F{1'b0}}}),
		.den(cfg.period), .side_in(nm_side_s),
		.out_v(sc_v), .quo(sc_quo), .rem(sc_rem), .side_out(sc_side)
	);

	lkw_interp #(.FRAC_BITS(F), .KB(KB)) u_interp (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_v(sc_v), .pos(sc_quo),
		.base_in(sc_side[SW-1:1]), .active_in(sc_side[0]), .cfg(cfg),
		.out_v(ip_v), .u(ip_u), .base_out(ip_base), .active_out(ip_act)
	);

	// division by the number of letter steps, long division a byte at a time
	for (genvar k = 0; k < D25_NS; k++) begin : g_div25
		logic              pv;
		logic [D25_UW-1:0] pnum, pquo;
		logic [KEY_W-1:0]  prem;
		logic [SW-1:0]     pside;
		logic [D25_VW-1:0] val, back;
		logic [PRD_W-1:0]  prd;
		logic [D25_CW-1:0] qd;

		if (k == 0) begin : g_first
			assign pv    = ip_v;
			assign pnum  = D25_UW'(ip_u);
			assign pquo  = '0;
			assign prem  = '0;
			assign pside = {ip_base, ip_act};
		end else begin : g_next
			assign pv    = d25_v_s[k-1];
			assign pnum  = d25_num_s[k-1];
			assign pquo  = d25_quo_s[k-1];
			assign prem  = d25_rem_s[k-1];
			assign pside = d25_side_s[k-1];
		end

		// partial remainder and next byte, quotient digit by reciprocal
		assign val  = {prem, pnum[D25_UW-1 -: D25_CW]};
		assign prd  = PRD_W'(val) * PRD_W'(RECIP25);
		assign qd   = prd[RECIP_SH +: D25_CW];
		assign back = val - D25_VW'(qd) * D25_VW'(LEVEL_STEPS);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				d25_v_s[k] <= 1'b0;
			else if (adv)
				d25_v_s[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d25_num_s[k]  <= pnum << D25_CW;
				d25_quo_s[k]  <= {pquo[D25_UW-D25_CW-1:0], qd};
				d25_rem_s[k]  <= back[KEY_W-1:0];
				d25_side_s[k] <= pside;
			end
		end
	end

	assign d25_v    = d25_v_s[D25_NS-1];
	assign d25_quo  = d25_quo_s[D25_NS-1][LVL_QW-1:0];
	assign d25_side = d25_side_s[D25_NS-1];

	assign mr   = mprod_s + HALF_C;
	assign msh  = mr >>> F;
	assign msat = (msh > 64'sd2147483647) ? 32'sh7fffffff :
		(msh < -64'sd2147483648) ? 32'sh80000000 : msh[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_v_s     <= 1'b0;
			mp_v_s      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			lvl_v_s     <= d25_v;
			mp_v_s      <= lvl_v_s;
			out_valid_q <= mp_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// remove the bias, the level always fits in 32 bits
			lvl_s      <= cfg.value_a + DATA_W'(d25_quo - QOFS);
			lvl_base_s <= d25_side[SW-1:1];
			lvl_act_s  <= d25_side[0];
			mprod_s    <= 64'(lvl_s) * 64'(lvl_base_s);
			mp_lvl_s   <= lvl_s;
			mp_base_s  <= lvl_base_s;
			mp_act_s   <= lvl_act_s;
			animated_q <= mp_act_s;
			if (!mp_act_s)
				level_q <= mp_base_s;
			else if (cfg.multiply)
				level_q <= msat;
			else
				level_q <= mp_lvl_s;
		end
	end

	assign out_valid = out_valid_q;
	assign level_out = level_q;
	assign animated  = animated_q;

	`LKW_ASSERT(a_stall_only_when_blocked, in_stall |-> (out_valid && out_stall), "input stalled without output back-pressure")
	`LKW_ASSERT_NEXT(a_frozen_on_stall, (out_valid && out_stall), ($stable(mod_v) && $stable(lvl_v_s) && $stable(mp_v_s)), "pipeline moved while output stalled")
	`LKW_ASSERT_NEXT(a_passthru, (adv && mp_v_s && !mp_act_s), (!animated && level_out == $past(mp_base_s)), "disabled transaction did not pass base value")

endmodule

`default_nettype wire

/* hw/rtl/lkw_cfg.sv */
// ----------------------------------------------------------------------------
// lkw_cfg
// configuration registers and the values derived from them
// ----------------------------------------------------------------------------
`default_nettype none

module lkw_cfg
	import lkw_pkg::*;
#(
	parameter int MAX_KEYS = DEF_MAX_KEYS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                      cfg
);

	logic signed [31:0] value_a_q;
	logic signed [31:0] value_z_q;
	logic [31:0]        period_q;
	logic [4:0]         key_count_q;
	logic [39:0]        keys_low_q;
	logic [39:0]        keys_high_q;
	logic               smooth_q;
	logic               multiply_q;
	logic [KEY_IDX_W-1:0] nm1_q;
	logic signed [32:0] delta_q;
	logic [4:0]         n;

	assign n = (key_count_q > 5'(MAX_KEYS)) ? 5'(MAX_KEYS) : key_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_a_q   <= RST_VALUE_A;
			value_z_q   <= RST_VALUE_Z;
			period_q    <= RST_PERIOD;
			key_count_q <= '0;
			keys_low_q  <= '0;
			keys_high_q <= '0;
			smooth_q    <= 1'b0;
			multiply_q  <= 1'b0;
			nm1_q       <= '0;
			delta_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_VALUE_A:   value_a_q   <= cfg_wdata[31:0];
					CFG_VALUE_Z:   value_z_q   <= cfg_wdata[31:0];
					CFG_PERIOD:    period_q    <= cfg_wdata[31:0];
					CFG_KEY_COUNT: key_count_q <= cfg_wdata[4:0];
					CFG_KEYS_LOW:  keys_low_q  <= cfg_wdata;
					CFG_KEYS_HIGH: keys_high_q <= cfg_wdata;
					CFG_SMOOTH:    smooth_q    <= cfg_wdata[0];
					CFG_MULTIPLY:  multiply_q  <= cfg_wdata[0];
					default: ;
				endcase
			end
			nm1_q    <= KEY_IDX_W'(n - 5'd1);
			delta_q  <= 33'(value_z_q) - 33'(value_a_q);
		end
	end

	// sampled as a transaction enters, so it follows the registers directly
	assign cfg.active   = (period_q != '0) && (n >= 5'd2);
	assign cfg.value_a  = value_a_q;
	assign cfg.period   = period_q;
	assign cfg.keys     = {keys_high_q, keys_low_q};
	assign cfg.smooth   = smooth_q;
	assign cfg.multiply = multiply_q;
	assign cfg.nm1      = nm1_q;
	assign cfg.delta    = delta_q;

endmodule

`default_nettype wire

/* hw/rtl/lkw_divpipe.sv */
// ----------------------------------------------------------------------------
// lkw_divpipe
// restoring divider, one quotient bit per pipeline stage, side data alongside
// ----------------------------------------------------------------------------
`default_nettype none

module lkw_divpipe #(
	parameter int QB = 32,
	parameter int DW = 32,
	parameter int SW = 33
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_v,
	input  wire logic [DW-1:0] rem_init,
	input  wire logic [QB-1:0] qn_init,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side_in,
	output logic               out_v,
	output logic [QB-1:0]      quo,
	output logic [DW-1:0]      rem,
	output logic [SW-1:0]      side_out
);

	// qn holds the numerator bits still to come on top and quotient bits below
	logic          v_s    [QB];
	logic [DW-1:0] rem_s  [QB];
	logic [QB-1:0] qn_s   [QB];
	logic [SW-1:0] side_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic          pv;
		logic [DW-1:0] prem;
		logic [QB-1:0] pqn;
		logic [SW-1:0] pside;
		logic [DW:0]   tmp;
		logic          ge;

		if (k == 0) begin : g_first
			assign pv    = in_v;
			assign prem  = rem_init;
			assign pqn   = qn_init;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign prem  = rem_s[k-1];
			assign pqn   = qn_s[k-1];
			assign pside = side_s[k-1];
		end

		assign tmp = {prem, pqn[QB-1]};
		assign ge  = tmp >= {1'b0, den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en)
				v_s[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DW'(tmp - {1'b0, den}) : tmp[DW-1:0];
				qn_s[k]   <= {pqn[QB-2:0], ge};
				side_s[k] <= pside;
			end
		end
	end

	assign out_v    = v_s[QB-1];
	assign quo      = qn_s[QB-1];
	assign rem      = rem_s[QB-1];
	assign side_out = side_s[QB-1];

endmodule

`default_nettype wire

/* hw/rtl/lkw_interp.sv */
// ----------------------------------------------------------------------------
// lkw_interp
// key lookup, interpolation and level product, three stages
// ----------------------------------------------------------------------------
`default_nettype none

module lkw_interp
	import lkw_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int KB        = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_v,
	input  wire logic [KB+FRAC_BITS-1:0] pos,
	input  wire logic [DATA_W-1:0]    base_in,
	input  wire logic                 active_in,
	input  wire cfg_t                 cfg,
	output logic                      out_v,
	output logic [LVL_UW-1:0]         u,
	output logic [DATA_W-1:0]         base_out,
	output logic                      active_out
);

	localparam int F   = FRAC_BITS;
	localparam int PW  = F + KEY_W;
	localparam int TW  = F + 7;
	localparam int PRW = 34 + PW;
	localparam logic signed [PRW-1:0] ROUND_C = PRW'(64'd25 << (F - 1));
	localparam logic [LVL_UW-1:0]     BIAS_C  = LVL_UW'(64'd25 << (LVL_QW - 1));

	logic [KB-1:0]       i0, i1;
	logic [F-1:0]        f;
	logic [KEY_W-1:0]    k0, k1;
	logic signed [5:0]   dk;
	logic signed [TW-1:0] term, pfull;

	logic                v_s1, v_s2, v_s3;
	logic [PW-1:0]       p_s1;
	logic signed [PRW-1:0] prod_s2;
	logic [LVL_UW-1:0]   u_s3;
	logic [DATA_W-1:0]   base_s1, base_s2, base_s3;
	logic                act_s1, act_s2, act_s3;
	logic signed [PRW-1:0] x;
	logic signed [LVL_QW-1:0] q;

	assign i0 = pos[KB+F-1:F];
	assign f  = pos[F-1:0];
	assign i1 = i0 + KB'(f != '0);
	assign k0 = key_at(cfg.keys, KEY_IDX_W'(i0));
	assign k1 = key_at(cfg.keys, KEY_IDX_W'(i1));
	assign dk = $signed({1'b0, k1}) - $signed({1'b0, k0});
	assign term  = dk * $signed({1'b0, f});
	assign pfull = $signed(TW'({k0, {F{1'b0}}})) + (cfg.smooth ? term : '0);

	// round half up, then floor by shifting
	assign x = prod_s2 + ROUND_C;
	assign q = x[PRW-1:F];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= pfull[PW-1:0];
			base_s1 <= base_in;
			act_s1  <= active_in;
			prod_s2 <= cfg.delta * $signed({1'b0, p_s1});
			base_s2 <= base_s1;
			act_s2  <= act_s1;
			// bias by a multiple of 25 so the division sees a positive value
			u_s3    <= LVL_UW'(q) + BIAS_C;
			base_s3 <= base_s2;
			act_s3  <= act_s2;
		end
	end

	assign out_v      = v_s3;
	assign u          = u_s3;
	assign base_out   = base_s3;
	assign active_out = act_s3;

endmodule

`default_nettype wire
